/* hdl/rmeu_pkg.sv */
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared types and constants of the register machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmeu_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int LINE_W = 16;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

    // status codes of a result
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BELOW   = 3'd1;
    localparam logic [2:0] ST_BEYOND  = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_PASTEND = 3'd4;

    // configuration register indexes
    localparam logic [0:0] CFG_DATA_BASE = 1'b0;
    localparam logic [0:0] CFG_LAST_LINE = 1'b1;

    typedef enum logic [3:0] {
        OP_LDI   = 4'd0,
        OP_MOVE  = 4'd1,
        OP_LDMEM = 4'd2,
        OP_STI   = 4'd3,
        OP_STMEM = 4'd4,
        OP_ADD   = 4'd5,
        OP_SUB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_DIV   = 4'd8,
        OP_JMP   = 4'd9,
        OP_JZ    = 4'd10,
        OP_JNZ   = 4'd11,
        OP_JGZ   = 4'd12,
        OP_JGEZ  = 4'd13,
        OP_JLZ   = 4'd14,
        OP_JLEZ  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

/* hdl/rmeu_ram.sv */
// ----------------------------------------------------------------------------
// rmeu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/rmeu_alu.sv */
// ----------------------------------------------------------------------------
// rmeu_alu
// Shared arithmetic unit: one 33-bit adder used for add, subtract,
// shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmeu_alu import rmeu_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alu_req_t          req,
    input  wire logic [DATA_W-1:0] opa,
    input  wire logic [DATA_W-1:0] opb,
    output alu_rsp_t               rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_ONE,
        A_ABS_A,
        A_ABS_B,
        A_ITER,
        A_FIX
    } alu_state_t;

    alu_state_t        state_reg;
    alu_op_t           op_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic              done_reg;
    logic [DATA_W-1:0] result_reg;

    logic [DATA_W-1:0] add_p;
    logic [DATA_W-1:0] add_q;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;

    // operand selection for the one shared adder
    always_comb begin
        add_p   = x_reg;
        add_q   = y_reg;
        add_sub = 1'b0;
        case (state_reg)
            A_ONE: begin
                add_sub = (op_reg == ALU_SUB);
            end
            A_ABS_A: begin
                add_p   = '0;
                add_q   = x_reg;
                add_sub = 1'b1;
            end
            A_ABS_B: begin
                add_p   = '0;
                add_q   = y_reg;
                add_sub = 1'b1;
            end
            A_ITER: begin
                if (op_reg == ALU_DIV) begin
                    // remainder stays below the divisor, so no bit is lost
                    add_p   = {acc_reg[DATA_W-2:0], x_reg[DATA_W-1]};
                    add_q   = y_reg;
                    add_sub = 1'b1;
                end else begin
                    add_p = acc_reg;
                    add_q = x_reg;
                end
            end
            A_FIX: begin
                add_p   = '0;
                add_q   = x_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_p} + {1'b0, (add_sub ? ~add_q : add_q)}
                + {{DATA_W{1'b0}}, add_sub};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    done_reg <= 1'b0;
                    if (req.start) begin
                        op_reg  <= req.op;
                        x_reg   <= opa;
                        y_reg   <= opb;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        neg_reg <= opa[DATA_W-1] ^ opb[DATA_W-1];
                        case (req.op)
                            ALU_MUL: state_reg <= A_ITER;
                            ALU_DIV: state_reg <= A_ABS_A;
                            default: state_reg <= A_ONE;
                        endcase
                    end
                end
                A_ONE: begin
                    result_reg <= add_sum[DATA_W-1:0];
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                A_ABS_A: begin
                    if (x_reg[DATA_W-1]) begin
                        x_reg <= add_sum[DATA_W-1:0];
                    end
                    state_reg <= A_ABS_B;
                end
                A_ABS_B: begin
                    if (y_reg[DATA_W-1]) begin
                        y_reg <= add_sum[DATA_W-1:0];
                    end
                    state_reg <= A_ITER;
                end
                A_ITER: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (op_reg == ALU_DIV) begin
                        // carry out set means no borrow: quotient bit is one
                        if (add_sum[DATA_W]) begin
                            acc_reg <= add_sum[DATA_W-1:0];
                        end else begin
                            acc_reg <= add_p;
                        end
                        x_reg <= {x_reg[DATA_W-2:0], add_sum[DATA_W]};
                        if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                            state_reg <= A_FIX;
                        end
                    end else begin
                        if (y_reg[0]) begin
                            acc_reg <= add_sum[DATA_W-1:0];
                        end
                        x_reg <= {x_reg[DATA_W-2:0], 1'b0};
                        y_reg <= {1'b0, y_reg[DATA_W-1:1]};
                        if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                            result_reg <= y_reg[0] ? add_sum[DATA_W-1:0] : acc_reg;
                            done_reg   <= 1'b1;
                            state_reg  <= A_IDLE;
                        end
                    end
                end
                A_FIX: begin
                    result_reg <= neg_reg ? add_sum[DATA_W-1:0] : x_reg;
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                default: begin
                    done_reg  <= 1'b0;
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy   = (state_reg != A_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

/* hdl/register_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes one decoded instruction per transfer for a small register machine.
// ----------------------------------------------------------------------------
// One decoded instruction arrives per s_ transfer and exactly one result
// leaves per m_ transfer. Configuration (data base, last program line) is
// written through cfg_we/cfg_index/cfg_wdata, by the user only while the
// unit is idle; the unit itself does not enforce this. An instruction is
// taken only in the idle state; it then steps through two register file
// reads (one read port), an execute step and, for a memory load, a memory
// read or, for arithmetic, the shared iterative unit. The shift-add
// multiply and restoring divide in the shared adder take one bit per
// cycle and are the slowest operations.
// The result is held in an output register, so the next instruction is
// taken while an earlier result waits for m_tready; a stalled receiver
// holds the unit only once a second result is ready to be handed over.
// After reset the registers read zero and the data memory is swept to the
// most negative value, one word per cycle, while s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module register_machine_execute_unit import rmeu_pkg::*; #(
    parameter int MEM_WORDS = 16384,
    parameter int NUM_REGS  = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // instruction in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op, src_a, src_b, dest, use_imm, imm, address, target (lowest first)
    input  wire logic [87:0] s_tdata,
    // result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, write_value, branch_taken, branch_target (lowest first)
    output logic [55:0]      m_tdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = $clog2(NUM_REGS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_MEM_RD,
        S_WAIT_ALU,
        S_RESULT
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [LINE_W-1:0]  data_base_reg;
    logic [LINE_W-1:0]  last_line_reg;

    op_t                op_reg;
    logic [IDX_W-1:0]   src_a_reg;
    logic [IDX_W-1:0]   src_b_reg;
    logic [IDX_W-1:0]   dest_reg;
    logic               use_imm_reg;
    logic [DATA_W-1:0]  imm_reg;
    logic [LINE_W-1:0]  target_reg;
    logic [2:0]         mem_st_reg;
    logic [AW-1:0]      mem_idx_reg;
    logic [DATA_W-1:0]  a_reg;
    logic [DATA_W-1:0]  b_reg;

    logic [2:0]         res_status_reg;
    logic [DATA_W-1:0]  res_wv_reg;
    logic               res_taken_reg;
    logic [LINE_W-1:0]  res_target_reg;

    logic               m_tvalid_reg;
    logic [2:0]         out_status_reg;
    logic [DATA_W-1:0]  out_wv_reg;
    logic               out_taken_reg;
    logic [LINE_W-1:0]  out_target_reg;

    logic [DATA_W-1:0]  rf_reg [NUM_REGS];

    logic               accept;
    logic               out_load;
    logic [LINE_W:0]    in_diff;
    logic               in_beyond;
    logic [IDX_W-1:0]   rd_idx;
    logic [DATA_W-1:0]  rd_val;
    logic               rf_we;
    logic [DATA_W-1:0]  rf_wdata;
    logic               cond;
    logic               is_arith;
    logic               is_store;
    logic               div_zero;
    logic [2:0]         ex_status;
    logic [DATA_W-1:0]  ex_wv;
    logic               ex_taken;
    logic [LINE_W-1:0]  ex_target;
    state_t             ex_state;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // result moves into the output register when that is free or being emptied
    assign out_load = (state_reg == S_RESULT) && (!m_tvalid_reg || m_tready);

    // base subtraction on the incoming address
    assign in_diff   = {1'b0, s_tdata[64:49]} - {1'b0, data_base_reg};
    assign in_beyond = ({1'b0, in_diff[LINE_W-1:0]} >= (LINE_W+1)'(MEM_WORDS));

    // single register file read port, a first then b
    assign rd_idx = (state_reg == S_RD_A) ? src_a_reg : src_b_reg;
    assign rd_val = ({1'b0, rd_idx} < (IDX_W+1)'(NUM_REGS)) ? rf_reg[rd_idx[RW-1:0]] : '0;

    assign is_arith = (op_reg == OP_ADD) || (op_reg == OP_SUB)
                   || (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign is_store = (op_reg == OP_STI) || (op_reg == OP_STMEM);
    assign div_zero = (op_reg == OP_DIV) && (b_reg == '0);

    always_comb begin
        case (op_reg)
            OP_JMP:  cond = 1'b1;
            OP_JZ:   cond = (a_reg == '0);
            OP_JNZ:  cond = (a_reg != '0);
            OP_JGZ:  cond = (a_reg != '0) && !a_reg[DATA_W-1];
            OP_JGEZ: cond = !a_reg[DATA_W-1];
            OP_JLZ:  cond = a_reg[DATA_W-1];
            OP_JLEZ: cond = (a_reg == '0) || a_reg[DATA_W-1];
            default: cond = 1'b0;
        endcase
    end

    // outcome of the execute step
    always_comb begin
        ex_status = ST_OK;
        ex_wv     = '0;
        ex_taken  = 1'b0;
        ex_target = '0;
        ex_state  = S_RESULT;
        case (op_reg)
            OP_LDI: begin
                ex_wv = imm_reg;
            end
            OP_MOVE: begin
                ex_wv = a_reg;
            end
            OP_LDMEM: begin
                ex_status = mem_st_reg;
                if (mem_st_reg == ST_OK) begin
                    ex_state = S_MEM_RD;
                end
            end
            OP_STI, OP_STMEM: begin
                ex_status = mem_st_reg;
                if (mem_st_reg == ST_OK) begin
                    ex_wv = ram_wdata;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (div_zero) begin
                    ex_status = ST_DIVZERO;
                end else begin
                    ex_state = S_WAIT_ALU;
                end
            end
            default: begin
                if (cond) begin
                    if (target_reg > last_line_reg) begin
                        ex_status = ST_PASTEND;
                    end else begin
                        ex_taken  = 1'b1;
                        ex_target = target_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb begin
        alu_req.start = (state_reg == S_EXEC) && is_arith && !div_zero;
        case (op_reg)
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            OP_DIV:  alu_req.op = ALU_DIV;
            default: alu_req.op = ALU_ADD;
        endcase
    end

    always_comb begin
        rf_we    = 1'b0;
        rf_wdata = alu_rsp.result;
        case (state_reg)
            S_EXEC: begin
                rf_we    = (op_reg == OP_LDI) || (op_reg == OP_MOVE);
                rf_wdata = (op_reg == OP_LDI) ? imm_reg : a_reg;
            end
            S_MEM_RD: begin
                rf_we    = 1'b1;
                rf_wdata = ram_rdata;
            end
            S_WAIT_ALU: begin
                rf_we = alu_rsp.done;
            end
            default: begin
                rf_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = MOST_NEG;
        end else begin
            ram_we    = (state_reg == S_EXEC) && is_store && (mem_st_reg == ST_OK);
            ram_addr  = mem_idx_reg;
            ram_wdata = (op_reg == OP_STI) ? imm_reg : a_reg;
        end
    end

    rmeu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    rmeu_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (a_reg),
        .opb     (b_reg),
        .rsp     (alu_rsp)
    );

    // register file, writes to an index past the last register are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= '0;
            end
        end else if (rf_we && ({1'b0, dest_reg} < (IDX_W+1)'(NUM_REGS))) begin
            rf_reg[dest_reg[RW-1:0]] <= rf_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_base_reg <= '0;
            last_line_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DATA_BASE: data_base_reg <= cfg_wdata;
                CFG_LAST_LINE: last_line_reg <= cfg_wdata;
                default:       data_base_reg <= data_base_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MEM_WORDS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        op_reg      <= op_t'(s_tdata[3:0]);
                        src_a_reg   <= s_tdata[7:4];
                        src_b_reg   <= s_tdata[11:8];
                        dest_reg    <= s_tdata[15:12];
                        use_imm_reg <= s_tdata[16];
                        imm_reg     <= s_tdata[48:17];
                        target_reg  <= s_tdata[80:65];
                        mem_idx_reg <= in_diff[AW-1:0];
                        if (in_diff[LINE_W]) begin
                            mem_st_reg <= ST_BELOW;
                        end else if (in_beyond) begin
                            mem_st_reg <= ST_BEYOND;
                        end else begin
                            mem_st_reg <= ST_OK;
                        end
                        state_reg <= S_RD_A;
                    end
                end
                S_RD_A: begin
                    a_reg     <= rd_val;
                    state_reg <= S_RD_B;
                end
                S_RD_B: begin
                    b_reg     <= use_imm_reg ? imm_reg : rd_val;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_status_reg <= ex_status;
                    res_wv_reg     <= ex_wv;
                    res_taken_reg  <= ex_taken;
                    res_target_reg <= ex_target;
                    state_reg      <= ex_state;
                end
                S_MEM_RD: begin
                    res_wv_reg <= ram_rdata;
                    state_reg  <= S_RESULT;
                end
                S_WAIT_ALU: begin
                    if (alu_rsp.done) begin
                        res_wv_reg <= alu_rsp.result;
                        state_reg  <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // hand over once the output register is free or being emptied
                    if (out_load) begin
                        out_status_reg <= res_status_reg;
                        out_wv_reg     <= res_wv_reg;
                        out_taken_reg  <= res_taken_reg;
                        out_target_reg <= res_target_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_target_reg, out_taken_reg, out_wv_reg, out_status_reg};

    a_ready_alu_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !alu_rsp.busy)
        else $error("instruction taken while the shared unit is busy");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (state_reg == S_WAIT_ALU))
        else $error("shared unit result with no instruction waiting");

    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_EXEC)))
        else $error("memory write outside clearing or execute");

    a_taken_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_taken_reg) |-> (out_status_reg == ST_OK))
        else $error("branch taken with an error status");

endmodule

`default_nettype wire

/* verif/tb_register_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// tb_register_machine_execute_unit
// Self-checking bench for the register machine execute unit.
// ----------------------------------------------------------------------------
// A queue of decoded instructions feeds a stream driver. Every accepted
// instruction is run through a behavioural copy of the register file, the
// data memory and the two configuration registers, and the expected result
// is queued. The monitor compares each result transfer field by field.
// A short directed run covers the corner cases, then random instructions
// run under several base / last-line settings with varying back-pressure.
// ----------------------------------------------------------------------------

module tb_register_machine_execute_unit;
    import rmeu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WORDS      = 16384;
    localparam int NUM_REGS       = 9;
    localparam int WATCHDOG_LIMIT = 80000;   // must outlast the memory clearing sweep after reset
    localparam int CHUNK_ITEMS    = 100;

    typedef struct {
        op_t         op;
        logic [3:0]  src_a;
        logic [3:0]  src_b;
        logic [3:0]  dest;
        logic        use_imm;
        logic [31:0] imm;
        logic [15:0] address;
        logic [15:0] target;
    } instr_t;

    typedef struct {
        bit     drain;   // hold the sender until all results are back
        instr_t ins;
    } pend_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] write_value;
        logic        taken;
        logic [15:0] btarget;
    } result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = CFG_DATA_BASE;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;

    // behavioural state
    logic [31:0] reg_model [NUM_REGS];
    logic [31:0] mem_model [MEM_WORDS];
    logic [15:0] cfg_base;
    logic [15:0] cfg_last;

    pend_t   instr_q[$];
    result_t results_due[$];
    instr_t  cur_instr;
    bit      in_taken;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      err_cnt;
    int      idle_cycles;

    register_machine_execute_unit #(
        .MEM_WORDS (MEM_WORDS),
        .NUM_REGS  (NUM_REGS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t execute_instr(instr_t i);
        result_t     r;
        logic [31:0] a;
        logic [31:0] b;
        int          d;
        logic        cond;
        logic        wr;
        longint      q;
        r.status      = ST_OK;
        r.write_value = '0;
        r.taken       = 1'b0;
        r.btarget     = '0;
        wr            = 1'b0;
        cond          = 1'b0;
        a = (i.src_a < NUM_REGS) ? reg_model[i.src_a] : '0;
        b = i.use_imm ? i.imm : ((i.src_b < NUM_REGS) ? reg_model[i.src_b] : '0);
        d = int'(i.address) - int'(cfg_base);
        case (i.op)
            OP_LDI: begin
                r.write_value = i.imm;
                wr = 1'b1;
            end
            OP_MOVE: begin
                r.write_value = a;
                wr = 1'b1;
            end
            OP_LDMEM, OP_STI, OP_STMEM: begin
                if (d < 0) begin
                    r.status = ST_BELOW;
                end else if (d >= MEM_WORDS) begin
                    r.status = ST_BEYOND;
                end else if (i.op == OP_LDMEM) begin
                    r.write_value = mem_model[d];
                    wr = 1'b1;
                end else begin
                    r.write_value = (i.op == OP_STI) ? i.imm : a;
                    mem_model[d] = r.write_value;
                end
            end
            OP_ADD: begin
                r.write_value = a + b;
                wr = 1'b1;
            end
            OP_SUB: begin
                r.write_value = a - b;
                wr = 1'b1;
            end
            OP_MUL: begin
                r.write_value = a * b;
                wr = 1'b1;
            end
            OP_DIV: begin
                if (b == '0) begin
                    r.status = ST_DIVZERO;
                end else begin
                    // 64-bit quotient so that most negative over minus one wraps
                    q = longint'($signed(a)) / longint'($signed(b));
                    r.write_value = q[31:0];
                    wr = 1'b1;
                end
            end
            default: begin
                case (i.op)
                    OP_JMP:  cond = 1'b1;
                    OP_JZ:   cond = (a == '0);
                    OP_JNZ:  cond = (a != '0);
                    OP_JGZ:  cond = (a != '0) && !a[31];
                    OP_JGEZ: cond = !a[31];
                    OP_JLZ:  cond = a[31];
                    default: cond = (a == '0) || a[31];
                endcase
                if (cond) begin
                    if (i.target > cfg_last) begin
                        r.status = ST_PASTEND;
                    end else begin
                        r.taken   = 1'b1;
                        r.btarget = i.target + 16'd1;
                    end
                end
            end
        endcase
        if (wr && i.dest < NUM_REGS) begin
            reg_model[i.dest] = r.write_value;
        end
        return r;
    endfunction

    function automatic logic [3:0] pick_reg();
        if ($urandom_range(0, 9) == 0) begin
            return 4'($urandom_range(NUM_REGS, 15));
        end
        return 4'($urandom_range(0, NUM_REGS - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(0, 8)) - 32'd4;
            7:          return MOST_NEG;
            8:          return 32'h7FFF_FFFF;
            default:    return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic instr_t rand_instr();
        instr_t r;
        int     sel;
        int     k;
        r.op      = op_t'($urandom_range(0, 15));
        r.src_a   = pick_reg();
        r.src_b   = pick_reg();
        r.dest    = pick_reg();
        r.use_imm = 1'($urandom_range(0, 1));
        r.imm     = pick_value();
        r.address = 16'($urandom_range(0, 65535));
        r.target  = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            r.op = OP_LDI;
        end else if (sel < 13) begin
            r.op = OP_MOVE;
        end else if (sel < 43) begin
            r.op = op_t'($urandom_range(OP_LDMEM, OP_STMEM));
            // mostly a handful of words just above the base so loads see stores
            k = $urandom_range(0, 9);
            if (k < 7) begin
                r.address = cfg_base + 16'($urandom_range(0, 7));
            end else if (k == 7) begin
                r.address = cfg_base - 16'd1;
            end else if (k == 8) begin
                r.address = cfg_base + 16'(MEM_WORDS - 1) + 16'($urandom_range(0, 1));
            end
        end else if (sel < 75) begin
            r.op = op_t'($urandom_range(OP_ADD, OP_DIV));
        end else begin
            r.op = op_t'($urandom_range(OP_JMP, OP_JLEZ));
            if ($urandom_range(0, 9) < 6) begin
                r.target = cfg_last - 16'd1 + 16'($urandom_range(0, 2));
            end
        end
        return r;
    endfunction

    task automatic queue_instr(op_t op, logic [3:0] a, logic [3:0] b, logic [3:0] d,
                               logic ui, logic [31:0] imm, logic [15:0] addr,
                               logic [15:0] tgt);
        instr_t i;
        i.op      = op;
        i.src_a   = a;
        i.src_b   = b;
        i.dest    = d;
        i.use_imm = ui;
        i.imm     = imm;
        i.address = addr;
        i.target  = tgt;
        instr_q.push_back('{1'b0, i});
    endtask

    task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_DATA_BASE) begin
            cfg_base = val;
        end else begin
            cfg_last = val;
        end
    endtask

    task automatic apply_config(logic [15:0] base, logic [15:0] last);
        write_cfg(CFG_DATA_BASE, base);
        write_cfg(CFG_LAST_LINE, last);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (instr_q.size() != 0 || s_tvalid || results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // instruction driver
    always @(negedge aclk) begin
        pend_t nxt;
        if (!s_tvalid || in_taken) begin
            if (instr_q.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else if (instr_q[0].drain) begin
                if (results_due.size() == 0) begin
                    void'(instr_q.pop_front());
                end
                s_tvalid <= 1'b0;
            end else begin
                nxt = instr_q.pop_front();
                cur_instr <= nxt.ins;
                s_tdata   <= {7'd0, nxt.ins.target, nxt.ins.address, nxt.ins.imm,
                              nxt.ins.use_imm, nxt.ins.dest, nxt.ins.src_b,
                              nxt.ins.src_a, nxt.ins.op};
                s_tvalid  <= 1'b1;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready) begin
            got.status      = m_tdata[2:0];
            got.write_value = m_tdata[34:3];
            got.taken       = m_tdata[35];
            got.btarget     = m_tdata[51:36];
            if (results_due.size() == 0) begin
                $error("result transfer with nothing expected: status %0d value %0h",
                       got.status, got.write_value);
                err_cnt++;
            end else begin
                want = results_due.pop_front();
                check_field("status", want.status, got.status);
                check_field("write_value", want.write_value, got.write_value);
                check_field("branch_taken", want.taken, got.taken);
                check_field("branch_target", want.btarget, got.btarget);
            end
        end
        in_taken = s_tvalid && s_tready;
        if (in_taken) begin
            results_due.push_back(execute_instr(cur_instr));
        end
        if (in_taken || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (reg_model[k]) reg_model[k] = '0;
        foreach (mem_model[k]) mem_model[k] = MOST_NEG;
        cfg_base      = 16'd0;
        cfg_last      = 16'hFFFF;
        err_cnt       = 0;
        idle_cycles   = 0;
        in_taken      = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 71;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // memory sweep runs first
        do @(negedge aclk); while (!s_tready);

        // corner cases with a raised base and a short program
        apply_config(16'd16, 16'd100);
        queue_instr(OP_LDI,   0, 0, 1,  0, MOST_NEG,     0, 0);
        queue_instr(OP_LDI,   0, 0, 2,  0, 32'hFFFF_FFFF, 0, 0);
        queue_instr(OP_DIV,   1, 2, 3,  0, 0,            0, 0);
        queue_instr(OP_DIV,   1, 0, 4,  1, 0,            0, 0);
        queue_instr(OP_LDI,   0, 0, 15, 0, 7,            0, 0);
        queue_instr(OP_MOVE,  15, 0, 5, 0, 0,            0, 0);
        queue_instr(OP_STI,   0, 0, 0,  0, 5,            15, 0);
        queue_instr(OP_STI,   0, 0, 0,  0, 32'h7FFF_FFFF, 16, 0);
        queue_instr(OP_STMEM, 1, 0, 0,  0, 0,            16'(16 + MEM_WORDS - 1), 0);
        queue_instr(OP_STMEM, 1, 0, 0,  0, 0,            16'(16 + MEM_WORDS), 0);
        queue_instr(OP_LDMEM, 0, 0, 6,  0, 0,            16, 0);
        queue_instr(OP_LDMEM, 0, 0, 7,  0, 0,            16'(16 + MEM_WORDS - 1), 0);
        queue_instr(OP_LDMEM, 0, 0, 8,  0, 0,            17, 0);
        queue_instr(OP_ADD,   6, 0, 0,  1, 1,            0, 0);
        queue_instr(OP_SUB,   1, 0, 8,  1, 1,            0, 0);
        queue_instr(OP_MUL,   2, 2, 0,  0, 0,            0, 0);
        queue_instr(OP_JMP,   0, 0, 0,  0, 0,            0, 100);
        queue_instr(OP_JMP,   0, 0, 0,  0, 0,            0, 101);
        queue_instr(OP_JZ,    5, 0, 0,  0, 0,            0, 3);
        queue_instr(OP_JNZ,   5, 0, 0,  0, 0,            0, 200);
        queue_instr(OP_JGZ,   6, 0, 0,  0, 0,            0, 50);
        queue_instr(OP_JGEZ,  5, 0, 0,  0, 0,            0, 60);
        queue_instr(OP_JLZ,   1, 0, 0,  0, 0,            0, 70);
        queue_instr(OP_JLEZ,  5, 0, 0,  0, 0,            0, 500);
        wait_drained();
        // branch target wrap and a load far past the end of memory
        apply_config(16'd0, 16'hFFFF);
        queue_instr(OP_JMP,   0, 0, 0,  0, 0,            0, 16'hFFFF);
        queue_instr(OP_LDMEM, 0, 0, 3,  0, 0,            16'hFFFF, 0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                wait_drained();
                case ((phase * 3 + chunk) % 4)
                    0:       apply_config(16'd0, 16'hFFFF);
                    1:       apply_config(16'hFFFF, 16'd0);
                    2:       apply_config(16'($urandom_range(0, 300)),
                                          16'($urandom_range(0, 65535)));
                    default: apply_config(16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535)));
                endcase
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    if (n == CHUNK_ITEMS / 2) begin
                        instr_q.push_back('{1'b1, rand_instr()});
                    end
                    instr_q.push_back('{1'b0, rand_instr()});
                end
            end
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
